/* design/satlb_pkg.sv */
// ----------------------------------------------------------------------------
// satlb_pkg - shared types and constants of the set-associative TLB
// Geometry, entry layout, status and opcode codes, and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package satlb_pkg;

	// Geometry. SETS is a power of two: the set index is the low VPN bits.
	localparam int SETS    = 16;
	localparam int WAYS    = 4;
	localparam int VPN_W   = 20;
	localparam int FRAME_W = 20;
	localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int TAG_W   = VPN_W - $clog2(SETS);
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int OLD_W   = RANK_W + 1;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_FILL   = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_MISS      = 2'd0,
		ST_HIT       = 2'd1,
		ST_HIT_DIRTY = 2'd2,
		ST_FILLED    = 2'd3
	} status_t;

	// One way of a set row as held in the set RAM.
	typedef struct packed {
		logic              dirty;
		logic [RANK_W-1:0] rank;
		logic [TAG_W-1:0]  tag;
		logic [FRAME_W-1:0] frame;
	} way_entry_t;

	typedef way_entry_t [WAYS-1:0] set_row_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;  // latch the accepted word and read its set row
		logic update;   // resolve, write the row back, load the output word
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_ready; // output register can take a word this cycle
	} dp_sts_t;

endpackage

`default_nettype wire

/* design/satlb_ctrl.sv */
// ----------------------------------------------------------------------------
// satlb_ctrl - sequencing of one TLB access
// Two-state machine: take a word and read its set, then resolve and write
// back once the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module satlb_ctrl
	import satlb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_LOOKUP = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.update  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (sts.out_ready) begin
					cmd.update = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	// An accepted word always goes on to resolve.
	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_LOOKUP))
		else $error("accepted word did not move to lookup");

	// Resolve waits on the output register and then frees the input side.
	a_lookup_release: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOKUP && sts.out_ready) |=> !in_stall)
		else $error("input side not released after resolve");
`endif

endmodule

`default_nettype wire

/* design/satlb_dp.sv */
// ----------------------------------------------------------------------------
// satlb_dp - TLB datapath
// Set RAM with one row per set, valid flops, tag compare, LRU rank update
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module satlb_dp
	import satlb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_sts_t                 sts,
	input  wire logic               opcode,
	input  wire logic [VPN_W-1:0]   virtual_page,
	input  wire logic               is_write,
	input  wire logic [FRAME_W-1:0] pte_frame,
	input  wire logic               pte_dirty,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [FRAME_W-1:0]      frame
);

	// Set RAM, read at capture and written at update.
	set_row_t mem [SETS];

	logic [WAYS-1:0] valid_q [SETS];

	// Stage 1: accepted word and its set row.
	opcode_t            op_s1;
	logic [SET_W-1:0]   set_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic               wr_s1;
	logic [FRAME_W-1:0] pframe_s1;
	logic               pdirty_s1;
	set_row_t           row_s1;
	logic [WAYS-1:0]    valid_s1;

	logic               out_valid_q;
	status_t            status_q;
	logic [FRAME_W-1:0] frame_q;

	logic [SET_W-1:0]   in_set;
	logic [TAG_W-1:0]   in_tag;

	logic [WAYS-1:0]    hit_vec;
	logic               hit_any;
	logic [WAY_W-1:0]   hit_way;
	logic               free_any;
	logic [WAY_W-1:0]   free_way;
	logic [WAY_W-1:0]   lru_way;
	logic [WAY_W-1:0]   pick;
	logic [OLD_W-1:0]   old_rank;
	logic               row_we;
	set_row_t           new_row;
	status_t            res_status;
	logic [FRAME_W-1:0] res_frame;

	assign in_set = SET_W'(virtual_page % SETS);
	assign in_tag = TAG_W'(virtual_page / SETS);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1     <= opcode_t'(opcode);
			set_s1    <= in_set;
			tag_s1    <= in_tag;
			wr_s1     <= is_write;
			pframe_s1 <= pte_frame;
			pdirty_s1 <= pte_dirty;
			row_s1    <= mem[in_set];
			valid_s1  <= valid_q[in_set];
		end
		if (cmd.update && row_we) begin
			mem[set_s1] <= new_row;
		end
	end

	// Tag compare, first free way and LRU way, lowest way wins.
	always_comb begin
		hit_vec  = '0;
		hit_any  = 1'b0;
		hit_way  = '0;
		free_any = 1'b0;
		free_way = '0;
		lru_way  = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			hit_vec[w] = valid_s1[w] && (row_s1[w].tag == tag_s1);
			if (hit_vec[w]) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!valid_s1[w]) begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
			if (row_s1[w].rank == RANK_W'(WAYS - 1)) begin
				lru_way = WAY_W'(w);
			end
		end
	end

	// Pick the way, age the more recent valid ways, build the new row.
	always_comb begin
		res_status = ST_MISS;
		res_frame  = '0;
		row_we     = 1'b0;
		pick       = hit_way;
		old_rank   = {1'b0, row_s1[hit_way].rank};
		if (op_s1 == OP_FILL) begin
			row_we     = 1'b1;
			res_status = ST_FILLED;
			if (free_any) begin
				pick     = free_way;
				old_rank = OLD_W'(WAYS);
			end else begin
				pick     = lru_way;
				old_rank = OLD_W'(WAYS - 1);
			end
		end else if (hit_any) begin
			row_we     = 1'b1;
			res_frame  = row_s1[hit_way].frame;
			res_status = (wr_s1 && !row_s1[hit_way].dirty) ? ST_HIT_DIRTY : ST_HIT;
		end

		new_row = row_s1;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == pick) begin
				new_row[w].rank = '0;
				if (op_s1 == OP_FILL) begin
					new_row[w].dirty = wr_s1 | pdirty_s1;
					new_row[w].tag   = tag_s1;
					new_row[w].frame = pframe_s1;
				end else begin
					new_row[w].dirty = row_s1[w].dirty | wr_s1;
				end
			end else if (valid_s1[w] && ({1'b0, row_s1[w].rank} < old_rank)) begin
				new_row[w].rank = row_s1[w].rank + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else if (cmd.update && op_s1 == OP_FILL) begin
			valid_q[set_s1][pick] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			status_q <= res_status;
			frame_q  <= res_frame;
		end
	end

	assign sts.out_ready = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign frame         = frame_q;

`ifndef ASSERT_OFF
	// Never overwrite a word that is still held by a stall.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !(out_valid_q && out_stall))
		else $error("output word overwritten while stalled");

	// Misses and fills carry no frame.
	a_zero_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_MISS || status_q == ST_FILLED)) |-> (frame_q == '0))
		else $error("nonzero frame on miss or fill");
`endif

endmodule

`default_nettype wire

/* design/set_assoc_tlb_lru.sv */
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru - set-associative TLB with true LRU replacement
// Lookup and fill of 4-way, 16-set translation entries, one word in and one
// result word out per access.
// ----------------------------------------------------------------------------
// An access runs in two steps. At the accepting edge the set row (tag,
// frame, dirty and LRU rank of every way) is read from the single-port set
// RAM; then, once the output register can take a word, the tags are
// compared, the LRU ranks are updated, the row is written back and the
// result word is loaded into the output register. The read-modify-write
// of one set row goes through that one RAM port, and the input stays stalled
// from acceptance until the row is written back, and longer while a finished
// result word waits in the output register. The set index is the low four
// bits of the virtual page and the tag is the upper sixteen. A lookup takes
// the lowest matching valid way, makes it most recent and returns its frame
// (status hit, or hit with dirty newly set when a write finds a clean entry);
// a miss returns status miss and frame zero. A fill does not look up first:
// it takes the lowest invalid way, else the least recently used one, and
// returns status filled with frame zero. Valid bits clear at reset; no RAM
// clearing pass is needed, so the block accepts words right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_tlb_lru
	import satlb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               opcode,
	input  wire logic [VPN_W-1:0]   virtual_page,
	input  wire logic               is_write,
	input  wire logic [FRAME_W-1:0] pte_frame,
	input  wire logic               pte_dirty,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [FRAME_W-1:0]      frame
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequence each access: capture and read, then resolve and write back.
	satlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the set RAM, valid bits, compare and LRU logic, result register.
	satlb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.virtual_page (virtual_page),
		.is_write     (is_write),
		.pte_frame    (pte_frame),
		.pte_dirty    (pte_dirty),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.frame        (frame)
	);

endmodule

`default_nettype wire

/* dv/set_assoc_tlb_lru_checker.sv */
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru_checker - result scoreboard for the set-associative TLB
// Watches both channels, keeps its own copy of the TLB contents and LRU
// ranks, predicts the result word of every accepted request and compares it
// with the words that leave the block, in order.
// ----------------------------------------------------------------------------
module set_assoc_tlb_lru_checker
	import satlb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               opcode,
	input  logic [VPN_W-1:0]   virtual_page,
	input  logic               is_write,
	input  logic [FRAME_W-1:0] pte_frame,
	input  logic               pte_dirty,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         status,
	input  logic [FRAME_W-1:0] frame,
	output int unsigned        errors,
	output int unsigned        pending,
	output int unsigned        n_miss,
	output int unsigned        n_hit,
	output int unsigned        n_hit_dirty,
	output int unsigned        n_fill,
	output int unsigned        n_evict
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = SETS * WAYS;

	typedef struct packed {
		status_t            status;
		logic [FRAME_W-1:0] frame;
	} xlate_word_t;

	logic               tlb_valid [ENTRIES];
	logic               tlb_dirty [ENTRIES];
	logic [TAG_W-1:0]   tlb_tag   [ENTRIES];
	logic [FRAME_W-1:0] tlb_frame [ENTRIES];
	int                 tlb_rank  [ENTRIES];

	xlate_word_t expected_words[$];

	// age every valid way more recent than old_rank, then make pick the newest
	function automatic void make_recent(int base, int pick, int old_rank);
		for (int w = 0; w < WAYS; w++) begin
			if (w != pick && tlb_valid[base + w] && tlb_rank[base + w] < old_rank)
				tlb_rank[base + w]++;
		end
		tlb_rank[base + pick] = 0;
	endfunction

	function automatic xlate_word_t translate(opcode_t op, logic [VPN_W-1:0] vpn, logic wr,
			logic [FRAME_W-1:0] pframe, logic pdirty);
		int               base;
		int               pick;
		int               old_rank;
		logic [TAG_W-1:0] tag;
		xlate_word_t      word;
		base = (vpn % SETS) * WAYS;
		tag = TAG_W'(vpn / SETS);
		word.status = ST_MISS;
		word.frame = '0;
		if (op == OP_LOOKUP) begin
			for (int w = 0; w < WAYS; w++) begin
				if (tlb_valid[base + w] && tlb_tag[base + w] == tag) begin
					make_recent(base, w, tlb_rank[base + w]);
					word.status = ST_HIT;
					word.frame = tlb_frame[base + w];
					if (wr && !tlb_dirty[base + w]) begin
						tlb_dirty[base + w] = 1'b1;
						word.status = ST_HIT_DIRTY;
					end
					return word;
				end
			end
			return word;
		end
		// fill: lowest invalid way, else the way of highest rank
		pick = -1;
		old_rank = WAYS;
		for (int w = 0; w < WAYS; w++) begin
			if (pick < 0 && !tlb_valid[base + w])
				pick = w;
		end
		if (pick < 0) begin
			pick = 0;
			old_rank = 0;
			for (int w = 0; w < WAYS; w++) begin
				if (tlb_rank[base + w] > old_rank) begin
					old_rank = tlb_rank[base + w];
					pick = w;
				end
			end
			n_evict++;
		end
		tlb_valid[base + pick] = 1'b1;
		tlb_dirty[base + pick] = wr | pdirty;
		tlb_tag[base + pick] = tag;
		tlb_frame[base + pick] = pframe;
		make_recent(base, pick, old_rank);
		word.status = ST_FILLED;
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		xlate_word_t want;
		if (!arst_n) begin
			for (int e = 0; e < ENTRIES; e++) begin
				tlb_valid[e] = 1'b0;
				tlb_dirty[e] = 1'b0;
				tlb_tag[e] = '0;
				tlb_frame[e] = '0;
				tlb_rank[e] = 0;
			end
			expected_words.delete();
			pending = 0;
		end else begin
			// retire first: a word leaving now belongs to an earlier request
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected word: expected none, got status %0d frame %05h",
						$realtime, status, frame);
				end else begin
					want = expected_words.pop_front();
					if (status !== want.status) begin
						errors++;
						$display("%0t: status mismatch: expected %0d, got %0d",
							$realtime, want.status, status);
					end
					if (frame !== want.frame) begin
						errors++;
						$display("%0t: frame mismatch: expected %05h, got %05h",
							$realtime, want.frame, frame);
					end
					case (want.status)
						ST_MISS:      n_miss++;
						ST_HIT:       n_hit++;
						ST_HIT_DIRTY: n_hit_dirty++;
						default:      n_fill++;
					endcase
				end
			end
			if (in_valid && !in_stall)
				expected_words.push_back(translate(opcode_t'(opcode), virtual_page, is_write,
					pte_frame, pte_dirty));
			pending = expected_words.size();
		end
	end

endmodule

/* dv/set_assoc_tlb_lru_tb.sv */
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru_tb - top-level testbench of the set-associative TLB
// Drives lookup and fill words into the block, with bursty requests and a
// stalling result side, and leaves prediction and checking to the checker
// instantiated beside the block. Prints the verdict at the end of the run.
// ----------------------------------------------------------------------------
module set_assoc_tlb_lru_tb;
	import satlb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 1100;
	// cycles with no word moving on either channel before the run is declared hung
	localparam int QUIET_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 10;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               opcode = OP_LOOKUP;
	logic [VPN_W-1:0]   virtual_page = '0;
	logic               is_write = 1'b0;
	logic [FRAME_W-1:0] pte_frame = '0;
	logic               pte_dirty = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [FRAME_W-1:0] frame;

	int unsigned errors, pending;
	int unsigned n_miss, n_hit, n_hit_dirty, n_fill, n_evict;
	int unsigned words_sent;
	int unsigned quiet_cycles;

	// hot working set: a few sets and tags that keep sets full and evicting
	logic [SET_W-1:0] hot_set [3];
	logic [TAG_W-1:0] hot_tag [6];

	set_assoc_tlb_lru u_top (.*);

	set_assoc_tlb_lru_checker u_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result-side stall: switch at random between no stall, random stall and
	// long stall runs, so stalls hit every access phase.
	int unsigned stall_mode, mode_left, stall_left;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			mode_left <= $urandom_range(32, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 99) < 35);
			default: begin
				if (stall_left != 0) begin
					out_stall <= 1'b1;
					stall_left <= stall_left - 1;
				end else begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 9) == 0)
						stall_left <= $urandom_range(2, 12);
				end
			end
		endcase
	end

	// Watchdog: end the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word accepted for %0d cycles", $realtime, QUIET_LIMIT);
			$display("** set_assoc_tlb_lru: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [VPN_W-1:0] vpn_of(logic [TAG_W-1:0] tag, logic [SET_W-1:0] set_idx);
		return {tag, set_idx};
	endfunction

	// Present one word at the falling edge and hold it until accepted.
	task automatic send_word(opcode_t op, logic [VPN_W-1:0] vpn, logic wr,
			logic [FRAME_W-1:0] pframe, logic pdirty);
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		virtual_page <= vpn;
		is_write <= wr;
		pte_frame <= pframe;
		pte_dirty <= pdirty;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic hold_off(int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Drop valid and wait until every predicted result word has come back.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [FRAME_W-1:0] pick_frame();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return FRAME_W'($urandom);
		endcase
	endfunction

	function automatic logic [VPN_W-1:0] pick_vpn();
		if ($urandom_range(0, 99) < 75)
			return vpn_of(hot_tag[$urandom_range(0, 5)], hot_set[$urandom_range(0, 2)]);
		return VPN_W'($urandom);
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic refresh_hot_set();
		foreach (hot_set[i])
			hot_set[i] = SET_W'($urandom);
		foreach (hot_tag[i])
			hot_tag[i] = TAG_W'($urandom);
		// keep the tag extremes in play
		if ($urandom_range(0, 1) == 1)
			hot_tag[0] = '0;
		if ($urandom_range(0, 1) == 1)
			hot_tag[1] = '1;
	endtask

	initial begin
		int unsigned      burst_left;
		logic [VPN_W-1:0] vpn;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// --- directed: extremes, both opcodes, dirty handling, LRU, duplicates
		send_word(OP_FILL,   vpn_of('0, '0), 1'b0, '1, 1'b0);
		send_word(OP_LOOKUP, vpn_of('0, '0), 1'b0, '0, 1'b0);  // hit
		send_word(OP_LOOKUP, vpn_of('0, '0), 1'b1, '0, 1'b0);  // write on clean: dirty set
		send_word(OP_LOOKUP, vpn_of('0, '0), 1'b1, '0, 1'b0);  // write on dirty: plain hit
		send_word(OP_LOOKUP, '1, 1'b0, '1, 1'b1);              // miss
		send_word(OP_FILL,   '1, 1'b0, '0, 1'b1);              // dirty from the PTE
		send_word(OP_LOOKUP, '1, 1'b1, '0, 1'b0);              // already dirty
		// fill one set past its ways: the oldest entry goes
		for (int t = 0; t < 5; t++)
			send_word(OP_FILL, vpn_of(TAG_W'(t), SET_W'(5)), 1'b0,
				FRAME_W'(20'h55500 + t), 1'b0);
		// evicted: miss
		send_word(OP_LOOKUP, vpn_of(TAG_W'(0), SET_W'(5)), 1'b0, '0, 1'b0);
		// promote tag 1
		send_word(OP_LOOKUP, vpn_of(TAG_W'(1), SET_W'(5)), 1'b0, '0, 1'b0);
		// evicts tag 2
		send_word(OP_FILL,   vpn_of(TAG_W'(5), SET_W'(5)), 1'b0, 20'hAAAAA, 1'b0);
		send_word(OP_LOOKUP, vpn_of(TAG_W'(2), SET_W'(5)), 1'b0, '0, 1'b0);
		send_word(OP_LOOKUP, vpn_of(TAG_W'(1), SET_W'(5)), 1'b0, '0, 1'b0);
		// duplicate fill: the lowest matching way still answers
		send_word(OP_FILL,   vpn_of('0, '0), 1'b0, 20'h12345, 1'b0);
		send_word(OP_LOOKUP, vpn_of('0, '0), 1'b0, '0, 1'b0);
		// write fill is dirty already; clean fill turns dirty on a write hit
		send_word(OP_FILL,   vpn_of(16'h1234, SET_W'(9)), 1'b1, 20'h0F0F0, 1'b0);
		send_word(OP_LOOKUP, vpn_of(16'h1234, SET_W'(9)), 1'b1, '0, 1'b0);
		send_word(OP_FILL,   vpn_of('1, SET_W'(9)), 1'b0, 20'hAAAAA, 1'b0);
		send_word(OP_LOOKUP, vpn_of('1, SET_W'(9)), 1'b1, '0, 1'b0);
		send_word(OP_LOOKUP, vpn_of('1, SET_W'(9)), 1'b0, '0, 1'b0);
		drain();

		// --- random: mostly miss, walk, fill, retry sequences on a hot set
		refresh_hot_set();
		burst_left = 0;
		while (words_sent < RANDOM_WORDS + 23) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0)
					hold_off($urandom_range(1, 6));
			end
			if (words_sent % 250 == 0) begin
				drain();
				refresh_hot_set();
			end
			vpn = pick_vpn();
			if ($urandom_range(0, 99) < 60) begin
				send_word(OP_LOOKUP, vpn, coin(), pick_frame(), coin());
				send_word(OP_FILL, vpn, coin(), pick_frame(), coin());
				send_word(OP_LOOKUP, vpn, coin(), pick_frame(), coin());
				burst_left = (burst_left > 3) ? burst_left - 3 : 0;
			end else begin
				send_word(opcode_t'(coin()), vpn, coin(), pick_frame(), coin());
				burst_left--;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d words: %0d misses, %0d hits, %0d hits setting dirty,",
			words_sent, n_miss, n_hit, n_hit_dirty);
		$display("%0d fills of which %0d replaced the LRU way; %0d check failures.",
			n_fill, n_evict, errors);
		if (errors == 0 && pending == 0) begin
			$display("** set_assoc_tlb_lru: PASSED **");
		end else begin
			$display("** set_assoc_tlb_lru: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
design/satlb_pkg.sv
design/satlb_ctrl.sv
design/satlb_dp.sv
design/set_assoc_tlb_lru.sv
dv/set_assoc_tlb_lru_checker.sv
dv/set_assoc_tlb_lru_tb.sv
